>>> rtl/arp_pkg.sv
`timescale 1ns / 1ps
package arp_pkg;
	localparam int PW = 15;
	localparam int NL = 6;
	localparam int PITCH_LIMIT = 12000;
	localparam logic [1:0] COUNTDOWN = 2'd3;
	localparam logic [1:0] LAUNCH = 2'd1;
	localparam logic [1:0] ORD_DOWN = 2'd0;
	localparam logic [1:0] ORD_RAND = 2'd1;
	localparam logic [1:0] WALK_DOWN = 2'd0;
	localparam logic [1:0] WALK_RAND = 2'd1;
	localparam logic [1:0] WALK_UP = 2'd2;
	localparam logic [1:0] REG_STEPS = 2'd0;
	localparam logic [1:0] REG_DIST = 2'd1;
	localparam logic [1:0] REG_ORDER = 2'd2;
	localparam logic [1:0] REG_WALK = 2'd3;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CTRL  = 5'b00010,
		ST_BUILD = 5'b00100,
		ST_PLAY  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		lfsr_next = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
	endfunction

	// reduce a draw modulo one to six pitches by masks or reciprocal multiplication
	function automatic logic [2:0] draw_mod(input logic [15:0] x, input logic [2:0] m);
		logic [33:0] p3, p5;
		logic [15:0] r;
		p3 = 34'(x) * 34'h0AAAB;
		p5 = 34'(x) * 34'h0CCCD;
		unique case (m)
			3'd2: r = {15'd0, x[0]};
			3'd3: r = x - p3[32:17] * 16'd3;
			3'd4: r = {14'd0, x[1:0]};
			3'd5: r = x - p5[33:18] * 16'd5;
			3'd6: r = x - p3[33:18] * 16'd6;
			default: r = '0;
		endcase
		draw_mod = r[2:0];
	endfunction
endpackage

>>> rtl/arp_lane.sv
`timescale 1ns / 1ps
module arp_lane import arp_pkg::*; (
	input  logic clk,
	input  logic signed [PW-1:0] pitch,
	input  logic signed [17:0] offset,
	output logic signed [PW-1:0] shifted_s1
);
	logic signed [18:0] sum;
	assign sum = 19'(pitch) + 19'(offset);
	always_ff @(posedge clk) begin
		if (sum > 19'sd12000) shifted_s1 <= PW'(PITCH_LIMIT);
		else if (sum < -19'sd12000) shifted_s1 <= -PW'(PITCH_LIMIT);
		else shifted_s1 <= sum[PW-1:0];
	end
endmodule

>>> rtl/arpeggiator_sequencer.sv
`timescale 1ns / 1ps
// Arpeggiator sequencer: one input word per audio tick gives one output word.
// Each word passes an accept state and a control state (which also makes the
// random walk draw), then, when a cycle of pitches starts, a build state that
// picks one connected pitch per step (each random draw steps the LFSR once),
// then lets the six clamp lanes settle and writes the table, or, when locked,
// goes on to play without writing the table; then a play state and an output
// state that presents the result. An empty pitch mask goes straight from
// control to the result. No word is accepted while a result is pending.
module arpeggiator_sequencer import arp_pkg::*; #(
	parameter int TRIG_HOLD_TICKS = 2,
	parameter int GATE_TICKS = 22,
	parameter int END_TICKS = 220
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// clock_edge, trigger_edge, trigger_connected, lock_press, button_press,
	// pitch_valid_mask[6], pitch_in_0..5[15 each]; 101 bits, padded to 104
	input  logic [103:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// pitch_out[15], gate, end_of_cycle, end_of_sequence, lock_lamp; padded
	output logic [23:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	state_t st_q;
	logic [4:0] steps_q, lsteps_q, step_idx_q;
	logic [3:0] dist_q, ldist_q, cyc_left_q;
	logic [1:0] ord_q, walk_q, lord_q, lwalk_q, seqcd_q, cyccd_q;
	logic lock_q, run_q, free_q;
	logic [5:0] steps_left_q;
	logic [2:0] cyc_idx_q;
	logic signed [5:0] walk_q_off;
	logic signed [PW-1:0] tab_q [NL];
	logic signed [PW-1:0] held_q;
	logic [3:0] trig_q;
	logic [9:0] gate_q, ecyc_q, eseq_q;
	logic [15:0] lfsr_q;
	logic [100:0] in_q;
	logic [2:0] pick_q [NL];
	logic [2:0] bi_q;
	logic launch_q, clocked_q;
	logic o_gate_q, o_eoc_q, o_eos_q;

	logic [5:0] mask;
	logic [2:0] n;
	logic signed [PW-1:0] vld [NL];
	logic signed [PW-1:0] shf [NL];
	logic signed [17:0] dv;

	assign mask = in_q[10:5];
	always_comb begin
		logic [2:0] k;
		k = '0;
		for (int i = 0; i < NL; i++) vld[i] = '0;
		for (int p = 0; p < NL; p++)
			if (mask[p]) begin
				vld[k] = in_q[11 + PW*p +: PW];
				k = k + 3'd1;
			end
		n = k;
	end

	assign dv = 18'($signed({1'b0, ldist_q}) * walk_q_off * 18'sd100);

	for (genvar g = 0; g < NL; g++) begin : g_lane
		arp_lane u_lane (.clk(clk), .pitch(vld[pick_q[g]]), .offset(dv),
			.shifted_s1(shf[g]));
	end

	assign s_tready = (st_q == ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_OUT);
	assign m_tdata = {5'd0, lock_q, o_eos_q, o_eoc_q, o_gate_q, held_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			steps_q <= 5'd1; dist_q <= '0; ord_q <= '0; walk_q <= '0;
			lock_q <= 1'b0; run_q <= 1'b0; free_q <= 1'b0;
			seqcd_q <= '0; cyccd_q <= '0;
			lsteps_q <= '0; ldist_q <= '0; lord_q <= '0; lwalk_q <= '0;
			step_idx_q <= '0; steps_left_q <= '0; cyc_idx_q <= '0; cyc_left_q <= '0;
			walk_q_off <= '0;
			for (int i = 0; i < NL; i++) begin
				tab_q[i] <= '0;
				pick_q[i] <= '0;
			end
			held_q <= '0;
			trig_q <= '0; gate_q <= '0; ecyc_q <= '0; eseq_q <= '0;
			lfsr_q <= LFSR_SEED;
			in_q <= '0; bi_q <= '0; launch_q <= 1'b0; clocked_q <= 1'b0;
			o_gate_q <= 1'b0; o_eoc_q <= 1'b0; o_eos_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							REG_STEPS: steps_q <= cfg_data;
							REG_DIST: dist_q <= cfg_data[3:0];
							REG_ORDER: ord_q <= cfg_data[1:0];
							REG_WALK: walk_q <= cfg_data[1:0];
							default: ;
						endcase
					end
					if (s_tvalid) begin
						in_q <= s_tdata[100:0];
						st_q <= ST_CTRL;
					end
				end
				ST_CTRL: begin
					logic [3:0] tr;
					logic th, clk_e, rn, fr;
					logic [1:0] sc, cc;
					logic [4:0] si, ls;
					logic [5:0] sl;
					logic [1:0] lw;
					logic [9:0] ec, es;
					if (n == 3'd0) begin
						o_gate_q <= gate_q != 0;
						o_eoc_q <= ecyc_q != 0;
						o_eos_q <= eseq_q != 0;
						st_q <= ST_OUT;
					end else begin
						tr = trig_q;
						if (in_q[1] && tr < 4'(TRIG_HOLD_TICKS)) tr = 4'(TRIG_HOLD_TICKS);
						th = tr != 0;
						if (th) tr = tr - 4'd1;
						trig_q <= tr;
						if (in_q[3]) lock_q <= ~lock_q;
						sc = seqcd_q; cc = cyccd_q;
						if (sc != 0) sc = sc - 2'd1;
						if (cc != 0) cc = cc - 2'd1;
						clk_e = in_q[0] && !th;
						if (in_q[1] || in_q[4]) begin sc = COUNTDOWN; cc = COUNTDOWN; end
						rn = run_q; fr = free_q;
						if (clk_e && !rn) begin
							if (!in_q[2]) begin
								fr = 1'b1; sc = COUNTDOWN; cc = LAUNCH;
							end else fr = 1'b0;
						end
						if (fr && in_q[2] && rn) fr = 1'b0;
						si = step_idx_q; sl = steps_left_q;
						ec = ecyc_q; es = eseq_q;
						if (rn && clk_e && cyc_left_q == 0) begin
							if (si < 5'd31) si = si + 5'd1;
							if (sl != 0) sl = sl - 6'd1;
							if (ec < 10'(END_TICKS)) ec = 10'(END_TICKS);
							if (sl == 0) begin
								if (fr) begin cc = COUNTDOWN; sc = COUNTDOWN; end
								rn = 1'b0;
								if (es < 10'(END_TICKS)) es = 10'(END_TICKS);
							end else cc = LAUNCH;
						end
						ecyc_q <= ec; eseq_q <= es;
						lw = lwalk_q;
						if (sc == LAUNCH) begin
							ls = lsteps_q;
							if (!lock_q ^ in_q[3]) begin
								ls = steps_q; ldist_q <= dist_q;
								lord_q <= ord_q; lwalk_q <= walk_q; lw = walk_q;
							end
							lsteps_q <= ls;
							sl = (ls != 0) ? {1'b0, ls} : 6'd1;
							si = '0;
							walk_q_off <= '0;
							rn = 1'b1;
						end
						seqcd_q <= sc; cyccd_q <= cc;
						step_idx_q <= si; steps_left_q <= sl;
						run_q <= rn; free_q <= fr;
						clocked_q <= clk_e;
						launch_q <= (cc == LAUNCH);
						if (cc == LAUNCH) begin
							logic [15:0] l;
							logic signed [5:0] wo;
							logic [1:0] d;
							l = lfsr_q; d = lw;
							wo = (sc == LAUNCH) ? 6'sd0 : walk_q_off;
							if (d == WALK_RAND) begin
								l = lfsr_next(l);
								d = l[0] ? WALK_UP : WALK_DOWN;
							end
							if (si != 0) begin
								if (d == WALK_DOWN && wo > -6'sd32) wo = wo - 6'sd1;
								else if (d == WALK_UP && wo < 6'sd31) wo = wo + 6'sd1;
							end
							walk_q_off <= wo;
							lfsr_q <= l;
							cyc_left_q <= {1'b0, n};
							cyc_idx_q <= '0;
							bi_q <= '0;
							st_q <= ST_BUILD;
						end else st_q <= ST_PLAY;
					end
				end
				ST_BUILD: begin
					logic [15:0] l;
					if (lock_q || bi_q == n + 3'd1) begin
						if (!lock_q) begin
							for (int i = 0; i < NL; i++)
								if (3'(i) < n) tab_q[i] <= shf[i];
						end
						st_q <= ST_PLAY;
					end else if (bi_q == n) begin
						bi_q <= bi_q + 3'd1;
					end else begin
						l = lfsr_q;
						if (lord_q == ORD_DOWN) pick_q[bi_q] <= n - bi_q - 3'd1;
						else if (lord_q == ORD_RAND) begin
							l = lfsr_next(l);
							pick_q[bi_q] <= draw_mod(l, n);
						end else pick_q[bi_q] <= bi_q;
						lfsr_q <= l;
						bi_q <= bi_q + 3'd1;
					end
				end
				ST_PLAY: begin
					logic [9:0] gc, c1, c2;
					gc = gate_q;
					if (run_q && (clocked_q || launch_q)) begin
						if (cyc_idx_q < 3'(NL)) held_q <= tab_q[cyc_idx_q];
						if (cyc_idx_q < 3'd7) cyc_idx_q <= cyc_idx_q + 3'd1;
						if (cyc_left_q != 0) cyc_left_q <= cyc_left_q - 4'd1;
						if (gc < 10'(GATE_TICKS)) gc = 10'(GATE_TICKS);
					end
					c1 = ecyc_q; c2 = eseq_q;
					o_gate_q <= gc != 0; o_eoc_q <= c1 != 0; o_eos_q <= c2 != 0;
					gate_q <= (gc != 0) ? gc - 10'd1 : gc;
					ecyc_q <= (c1 != 0) ? c1 - 10'd1 : c1;
					eseq_q <= (c2 != 0) ? c2 - 10'd1 : c2;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_hs_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output both open");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cyc_left_q <= 4'd6) else $error("cycle length above six");
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top import arp_pkg::*; ();

	typedef struct {
		bit clk_e, trg_e, trg_con, lock_p, btn_p;
		bit [5:0] mask;
		logic signed [14:0] pin [6];
	} tick_t;

	class arp_scoreboard;
		bit [4:0] steps = 1;
		bit [3:0] dist_v;
		bit [1:0] order, walk;
		bit lock_f, run_f, free_f;
		int seq_cd, cyc_cd;
		int l_steps, l_dist, l_order, l_walk;
		int step_idx, steps_left, cyc_idx, cyc_left, walk_off;
		int table_v [6];
		int held;
		int trig_cnt, gate_cnt, eoc_cnt, eos_cnt;
		bit [15:0] lfsr = LFSR_SEED;
		bit [23:0] expected [$];
		int errors;

		function int rnd();
			lfsr = lfsr_step(lfsr);
			return lfsr;
		endfunction

		function bit [15:0] lfsr_step(bit [15:0] s);
			return s[0] ? ((s >> 1) ^ 16'hB400) : (s >> 1);
		endfunction

		function void fire(ref int c, input int len);
			if (len > c) c = len;
		endfunction

		function bit pulse(ref int c);
			if (c == 0) return 0;
			c--;
			return 1;
		endfunction

		function void write_reg(bit [1:0] idx, bit [4:0] v);
			case (idx)
				REG_STEPS: steps = v;
				REG_DIST: dist_v = v[3:0];
				REG_ORDER: order = v[1:0];
				REG_WALK: walk = v[1:0];
			endcase
		endfunction

		function void note_tick(tick_t t);
			int vals [6];
			int n, dir, dv, v, k;
			bit trig_hi, clocked, g, ec, es;
			n = 0;
			for (int p = 0; p < 6; p++)
				if (t.mask[p]) begin
					vals[n] = t.pin[p];
					n++;
				end
			if (n > 0) begin
				if (t.trg_e) fire(trig_cnt, 2);
				trig_hi = pulse(trig_cnt);
				if (t.lock_p) lock_f = !lock_f;
				if (seq_cd) seq_cd--;
				if (cyc_cd) cyc_cd--;
				clocked = t.clk_e && !trig_hi;
				if (t.trg_e || t.btn_p) begin
					seq_cd = COUNTDOWN;
					cyc_cd = COUNTDOWN;
				end
				if (clocked && !run_f) begin
					if (!t.trg_con) begin
						free_f = 1;
						seq_cd = COUNTDOWN;
						cyc_cd = LAUNCH;
					end else
						free_f = 0;
				end
				if (free_f && t.trg_con && run_f) free_f = 0;
				if (run_f && clocked && cyc_left == 0) begin
					if (step_idx < 31) step_idx++;
					if (steps_left) steps_left--;
					fire(eoc_cnt, 220);
					if (steps_left == 0) begin
						if (free_f) begin
							cyc_cd = COUNTDOWN;
							seq_cd = COUNTDOWN;
						end
						run_f = 0;
						fire(eos_cnt, 220);
					end else
						cyc_cd = LAUNCH;
				end
				if (seq_cd == LAUNCH) begin
					if (!lock_f) begin
						l_steps = steps;
						l_dist = dist_v;
						l_order = order;
						l_walk = walk;
					end
					steps_left = l_steps ? l_steps : 1;
					step_idx = 0;
					walk_off = 0;
					run_f = 1;
				end
				if (cyc_cd == LAUNCH) begin
					dir = l_walk;
					cyc_left = n;
					cyc_idx = 0;
					if (dir == WALK_RAND) dir = (rnd() & 1) ? WALK_UP : WALK_DOWN;
					if (step_idx != 0) begin
						if (dir == WALK_DOWN && walk_off > -32) walk_off--;
						else if (dir == WALK_UP && walk_off < 31) walk_off++;
					end
					if (!lock_f) begin
						dv = l_dist * walk_off * 100;
						for (int i = 0; i < n; i++) begin
							if (l_order == ORD_DOWN) k = n - i - 1;
							else if (l_order == ORD_RAND) k = rnd() % n;
							else k = i;
							v = vals[k] + dv;
							if (v > 12000) v = 12000;
							if (v < -12000) v = -12000;
							table_v[i] = v;
						end
					end
				end
				if (run_f && (clocked || cyc_cd == LAUNCH)) begin
					if (cyc_idx < 6) held = table_v[cyc_idx];
					if (cyc_idx < 7) cyc_idx++;
					if (cyc_left) cyc_left--;
					fire(gate_cnt, 22);
				end
				g = pulse(gate_cnt);
				ec = pulse(eoc_cnt);
				es = pulse(eos_cnt);
			end else begin
				g = gate_cnt != 0;
				ec = eoc_cnt != 0;
				es = eos_cnt != 0;
			end
			expected.push_back({5'b0, lock_f, es, ec, g, 15'(held)});
		endfunction

		function void check_word(bit [23:0] got);
			bit [23:0] e;
			if (expected.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got[14:0] !== e[14:0])
				$display("%0t: pitch_out exp %0d got %0d", $time,
					$signed(e[14:0]), $signed(got[14:0]));
			if (got[15] !== e[15])
				$display("%0t: gate exp %b got %b", $time, e[15], got[15]);
			if (got[16] !== e[16])
				$display("%0t: end_of_cycle exp %b got %b", $time, e[16], got[16]);
			if (got[17] !== e[17])
				$display("%0t: end_of_sequence exp %b got %b", $time, e[17], got[17]);
			if (got[18] !== e[18])
				$display("%0t: lock_lamp exp %b got %b", $time, e[18], got[18]);
			if (got[18:0] !== e[18:0]) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	arp_scoreboard sb = new();
	bit quiet;

	arpeggiator_sequencer dut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_cfg(bit [1:0] idx, bit [4:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(idx, v);
	endtask

	task automatic set_all(bit [4:0] st, bit [4:0] d, bit [4:0] o, bit [4:0] w);
		write_cfg(REG_STEPS, st);
		write_cfg(REG_DIST, d);
		write_cfg(REG_ORDER, o);
		write_cfg(REG_WALK, w);
	endtask

	task automatic send(tick_t t);
		logic [103:0] d;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		d = '0;
		d[0] = t.clk_e;
		d[1] = t.trg_e;
		d[2] = t.trg_con;
		d[3] = t.lock_p;
		d[4] = t.btn_p;
		d[10:5] = t.mask;
		for (int p = 0; p < 6; p++) d[11 + 15 * p +: 15] = t.pin[p];
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_tick(t);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic tick_t rand_tick(int mode);
		tick_t t;
		int r;
		r = $urandom_range(0, 99);
		t.clk_e = (mode == 0) ? $urandom_range(0, 1) : (r < 45);
		t.trg_e = (mode == 0) ? $urandom_range(0, 1) : (r > 96);
		t.trg_con = (mode == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0);
		t.lock_p = $urandom_range(0, 40) == 0;
		t.btn_p = (mode == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 30) == 0);
		t.mask = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
		for (int p = 0; p < 6; p++)
			case ($urandom_range(0, 5))
				0: t.pin[p] = 15'sd12000;
				1: t.pin[p] = -15'sd12000;
				default: t.pin[p] = 15'($signed($urandom_range(0, 24000)) - 12000);
			endcase
		return t;
	endfunction

	function automatic tick_t fixed_tick(bit c, bit tr, bit tc, bit lk, bit b, bit [5:0] m,
			logic signed [14:0] base);
		tick_t t;
		t.clk_e = c; t.trg_e = tr; t.trg_con = tc; t.lock_p = lk; t.btn_p = b; t.mask = m;
		for (int p = 0; p < 6; p++) t.pin[p] = base + 15'(p * 700);
		return t;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 12);
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		tick_t t;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: free run, button start, trigger, lock, empty mask, extremes
		set_all(5'd16, 5'd12, 5'd2, 5'd2);
		send(fixed_tick(1, 0, 0, 0, 0, 6'h3F, -15'sd12000));
		for (int i = 0; i < 8; i++) send(fixed_tick(i[0], 0, 0, 0, 0, 6'h3F, 15'sd8000));
		send(fixed_tick(0, 0, 0, 1, 0, 6'h00, 15'sd0));
		send(fixed_tick(0, 1, 1, 1, 1, 6'h21, 15'sd12000));
		send(fixed_tick(1, 0, 1, 0, 0, 6'h21, -15'sd12000));
		send(fixed_tick(1, 0, 1, 0, 1, 6'h01, 15'sd100));
		send(fixed_tick(1, 1, 1, 1, 0, 6'h3F, 15'sd0));
		for (int i = 0; i < 6; i++) send(fixed_tick(1, 0, 0, 0, 0, 6'h3F, 15'sd0));
		drain();
		repeat (4) begin
			set_all(5'($urandom_range(0, 31)), 5'($urandom_range(0, 15)),
				5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)));
			for (int i = 0; i < 100; i++) begin
				t = rand_tick(i < 10 ? 0 : 1);
				send(t);
			end
			drain();
		end
		set_all(5'd1, 5'd0, 5'd1, 5'd1);
		quiet = 1;
		for (int i = 0; i < 60; i++) send(rand_tick(1));
		drain();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
